// ===== hw/rtl/pfe_pkg.sv =====
// Shared constants, types and symbol decode for the postfix expression evaluator.
package pfe_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int DATA_W      = 32;
   localparam int SYM_W       = 8;
   localparam int STATUS_W    = 3;
   localparam int CNT_W       = $clog2(DATA_W);

   localparam logic [STATUS_W-1:0] ERR_NONE      = 3'd0;
   localparam logic [STATUS_W-1:0] ERR_OVERFLOW  = 3'd1;
   localparam logic [STATUS_W-1:0] ERR_UNDERFLOW = 3'd2;
   localparam logic [STATUS_W-1:0] ERR_DIVZERO   = 3'd3;
   localparam logic [STATUS_W-1:0] ERR_UNKNOWN   = 3'd4;

   localparam logic [SYM_W-1:0] CHR_ZERO    = 8'h30;
   localparam logic [SYM_W-1:0] CHR_NINE    = 8'h39;
   localparam logic [SYM_W-1:0] CHR_UPPER_A = 8'h41;
   localparam logic [SYM_W-1:0] CHR_UPPER_Z = 8'h5A;
   localparam logic [SYM_W-1:0] CHR_LOWER_A = 8'h61;
   localparam logic [SYM_W-1:0] CHR_LOWER_Z = 8'h7A;
   localparam logic [SYM_W-1:0] CHR_PLUS    = 8'h2B;
   localparam logic [SYM_W-1:0] CHR_MINUS   = 8'h2D;
   localparam logic [SYM_W-1:0] CHR_STAR    = 8'h2A;
   localparam logic [SYM_W-1:0] CHR_SLASH   = 8'h2F;
   localparam logic [SYM_W-1:0] CHR_CARET   = 8'h5E;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_POW,
      OP_BAD
   } op_type;

   typedef struct packed {
      logic load;
      logic pop;
      logic cap_right;
      logic cap_left;
      logic cap_final;
      logic start_alu;
      logic push_operand;
      logic push_result;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_operand;
      logic last;
      logic alu_done;
      logic out_free;
   } stat_type;

   function automatic logic is_operand(input logic [SYM_W-1:0] sym);
      logic hit;
      case (sym) inside
         [CHR_ZERO:CHR_NINE],
         [CHR_UPPER_A:CHR_UPPER_Z],
         [CHR_LOWER_A:CHR_LOWER_Z]: hit = 1'b1;
         default:                   hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic op_type decode_op(input logic [SYM_W-1:0] sym);
      op_type op;
      case (sym)
         CHR_PLUS:  op = OP_ADD;
         CHR_MINUS: op = OP_SUB;
         CHR_STAR:  op = OP_MUL;
         CHR_SLASH: op = OP_DIV;
         CHR_CARET: op = OP_POW;
         default:   op = OP_BAD;
      endcase
      return op;
   endfunction

endpackage

// ===== hw/rtl/pfe_req_if.sv =====
// Request channel interface: one expression character per item.
interface pfe_req_if;
   logic                        valid;
   logic                        ready;
   logic [pfe_pkg::SYM_W-1:0]   symbol;
   logic                        last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ===== hw/rtl/pfe_rsp_if.sv =====
// Response channel interface: expression value and status per item.
interface pfe_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [pfe_pkg::DATA_W-1:0]  value;
   logic [pfe_pkg::STATUS_W-1:0]       status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== hw/rtl/pfe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pfe_ram #(
   parameter int WIDTH = pfe_pkg::DATA_W,
   parameter int DEPTH = pfe_pkg::STACK_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pfe_alu.sv =====
// Multi-cycle arithmetic unit: add, subtract, multiply, restoring divide, power.
module pfe_alu (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  pfe_pkg::op_type               op,
   input  logic [pfe_pkg::DATA_W-1:0]    left,
   input  logic [pfe_pkg::DATA_W-1:0]    right,
   output logic                          done,
   output logic [pfe_pkg::DATA_W-1:0]    result,
   output logic [pfe_pkg::STATUS_W-1:0]  err
);

   typedef enum logic [2:0] {
      A_IDLE,
      A_DIV,
      A_FIX,
      A_POW,
      A_DONE
   } state_type;

   state_type                       state_ff, state_in;
   logic [pfe_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [pfe_pkg::DATA_W-1:0]      q_ff, q_in;
   logic [pfe_pkg::DATA_W-1:0]      rem_ff, rem_in;
   logic [pfe_pkg::DATA_W-1:0]      div_ff, div_in;
   logic                            neg_ff, neg_in;
   logic [pfe_pkg::DATA_W-1:0]      acc_ff, acc_in;
   logic [pfe_pkg::DATA_W-1:0]      base_ff, base_in;
   logic [pfe_pkg::DATA_W-1:0]      exp_ff, exp_in;
   logic [pfe_pkg::DATA_W-1:0]      result_ff, result_in;
   logic [pfe_pkg::STATUS_W-1:0]    err_ff, err_in;

   logic [pfe_pkg::DATA_W-1:0]      mul_a, mul_b, prod, sq;
   logic [pfe_pkg::DATA_W:0]        rem_sh, diff;
   logic                            ge;

   assign mul_a  = (state_ff == A_POW) ? acc_ff : left;
   assign mul_b  = (state_ff == A_POW) ? base_ff : right;
   assign prod   = mul_a * mul_b;
   assign sq     = base_ff * base_ff;
   assign rem_sh = {rem_ff, q_ff[pfe_pkg::DATA_W-1]};
   assign diff   = rem_sh - {1'b0, div_ff};
   assign ge     = rem_sh >= {1'b0, div_ff};

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      q_in      = q_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      exp_in    = exp_ff;
      result_in = result_ff;
      err_in    = err_ff;
      case (state_ff)
         A_IDLE: begin
            if (start) begin
               err_in = pfe_pkg::ERR_NONE;
               case (op)
                  pfe_pkg::OP_ADD: begin
                     result_in = left + right;
                     state_in  = A_DONE;
                  end
                  pfe_pkg::OP_SUB: begin
                     result_in = left - right;
                     state_in  = A_DONE;
                  end
                  pfe_pkg::OP_MUL: begin
                     result_in = prod;
                     state_in  = A_DONE;
                  end
                  pfe_pkg::OP_DIV: begin
                     if (right == '0) begin
                        result_in = '0;
                        err_in    = pfe_pkg::ERR_DIVZERO;
                        state_in  = A_DONE;
                     end else begin
                        q_in     = left[pfe_pkg::DATA_W-1] ? -left : left;
                        div_in   = right[pfe_pkg::DATA_W-1] ? -right : right;
                        rem_in   = '0;
                        neg_in   = left[pfe_pkg::DATA_W-1] ^ right[pfe_pkg::DATA_W-1];
                        cnt_in   = '0;
                        state_in = A_DIV;
                     end
                  end
                  pfe_pkg::OP_POW: begin
                     if (right[pfe_pkg::DATA_W-1] || right == '0) begin
                        result_in = pfe_pkg::DATA_W'(1);
                        state_in  = A_DONE;
                     end else begin
                        acc_in   = pfe_pkg::DATA_W'(1);
                        base_in  = left;
                        exp_in   = right;
                        state_in = A_POW;
                     end
                  end
                  default: begin
                     result_in = '0;
                     err_in    = pfe_pkg::ERR_UNKNOWN;
                     state_in  = A_DONE;
                  end
               endcase
            end
         end
         A_DIV: begin
            rem_in = ge ? diff[pfe_pkg::DATA_W-1:0] : rem_sh[pfe_pkg::DATA_W-1:0];
            q_in   = {q_ff[pfe_pkg::DATA_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == pfe_pkg::CNT_W'(pfe_pkg::DATA_W - 1)) begin
               state_in = A_FIX;
            end
         end
         A_FIX: begin
            result_in = neg_ff ? -q_ff : q_ff;
            state_in  = A_DONE;
         end
         A_POW: begin
            if (exp_ff == '0) begin
               result_in = acc_ff;
               state_in  = A_DONE;
            end else begin
               if (exp_ff[0]) begin
                  acc_in = prod;
               end
               base_in = sq;
               exp_in  = exp_ff >> 1;
            end
         end
         A_DONE: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff    <= cnt_in;
      q_ff      <= q_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
      base_ff   <= base_in;
      exp_ff    <= exp_in;
      result_ff <= result_in;
      err_ff    <= err_in;
   end

   assign done   = (state_ff == A_DONE);
   assign result = result_ff;
   assign err    = err_ff;

endmodule

// ===== hw/rtl/pfe_ctrl.sv =====
// Controller state machine: sequences pops, operation, push and result per item.
module pfe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pfe_pkg::stat_type stat,
   output pfe_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      C_IDLE,
      C_DECODE,
      C_PUSH_OPND,
      C_POP_R,
      C_CAP_R,
      C_POP_L,
      C_CAP_L,
      C_START,
      C_WAIT,
      C_PUSH_RES,
      C_FIN_POP,
      C_FIN_CAP,
      C_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         C_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = C_DECODE;
            end
         end
         C_DECODE: begin
            state_in = stat.is_operand ? C_PUSH_OPND : C_POP_R;
         end
         C_PUSH_OPND: begin
            cmd.push_operand = 1'b1;
            state_in         = stat.last ? C_FIN_POP : C_IDLE;
         end
         C_POP_R: begin
            cmd.pop  = 1'b1;
            state_in = C_CAP_R;
         end
         C_CAP_R: begin
            cmd.cap_right = 1'b1;
            state_in      = C_POP_L;
         end
         C_POP_L: begin
            cmd.pop  = 1'b1;
            state_in = C_CAP_L;
         end
         C_CAP_L: begin
            cmd.cap_left = 1'b1;
            state_in     = C_START;
         end
         C_START: begin
            cmd.start_alu = 1'b1;
            state_in      = C_WAIT;
         end
         C_WAIT: begin
            if (stat.alu_done) begin
               state_in = C_PUSH_RES;
            end
         end
         C_PUSH_RES: begin
            cmd.push_result = 1'b1;
            state_in        = stat.last ? C_FIN_POP : C_IDLE;
         end
         C_FIN_POP: begin
            cmd.pop  = 1'b1;
            state_in = C_FIN_CAP;
         end
         C_FIN_CAP: begin
            cmd.cap_final = 1'b1;
            state_in      = C_EMIT;
         end
         C_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/pfe_datapath.sv =====
// Datapath: item register, operand stack, operand registers, status and result register.
module pfe_datapath #(
   parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pfe_pkg::cmd_type              cmd,
   output pfe_pkg::stat_type             stat,
   input  logic [pfe_pkg::SYM_W-1:0]     req_symbol,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pfe_pkg::DATA_W-1:0]    rsp_value,
   output logic [pfe_pkg::STATUS_W-1:0]  rsp_status
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [pfe_pkg::SYM_W-1:0]     sym_ff, sym_in;
   logic                          last_ff, last_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [pfe_pkg::STATUS_W-1:0]  err_ff, err_in;
   logic                          hit_ff, hit_in;
   logic [pfe_pkg::DATA_W-1:0]    right_ff, right_in;
   logic [pfe_pkg::DATA_W-1:0]    left_ff, left_in;
   logic [pfe_pkg::DATA_W-1:0]    final_ff, final_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pfe_pkg::DATA_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [pfe_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic [CW-1:0]                 count_m1;
   logic                          wr_en, rd_en;
   logic [pfe_pkg::DATA_W-1:0]    wr_data, rd_data, operand_val, popped;
   logic                          alu_done;
   logic [pfe_pkg::DATA_W-1:0]    alu_result;
   logic [pfe_pkg::STATUS_W-1:0]  alu_err;

   assign count_m1    = count_ff - 1'b1;
   assign operand_val = pfe_pkg::DATA_W'(sym_ff) - pfe_pkg::DATA_W'(pfe_pkg::CHR_ZERO);
   assign popped      = hit_ff ? rd_data : '0;

   always_comb begin
      sym_in        = sym_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      hit_in        = hit_ff;
      right_in      = right_ff;
      left_in       = left_ff;
      final_in      = final_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      wr_data       = cmd.push_result ? alu_result : operand_val;

      if (cmd.load) begin
         sym_in  = req_symbol;
         last_in = req_last;
      end

      if (cmd.pop) begin
         if (count_ff != '0) begin
            rd_en    = 1'b1;
            count_in = count_m1;
            hit_in   = 1'b1;
         end else begin
            hit_in = 1'b0;
            if (err_in == pfe_pkg::ERR_NONE) begin
               err_in = pfe_pkg::ERR_UNDERFLOW;
            end
         end
      end

      if (cmd.cap_right) begin
         right_in = popped;
      end
      if (cmd.cap_left) begin
         left_in = popped;
      end
      if (cmd.cap_final) begin
         final_in = popped;
      end

      if (cmd.push_result && alu_err != pfe_pkg::ERR_NONE && err_in == pfe_pkg::ERR_NONE) begin
         err_in = alu_err;
      end

      if (cmd.push_operand || cmd.push_result) begin
         if (count_ff == CW'(STACK_DEPTH)) begin
            if (err_in == pfe_pkg::ERR_NONE) begin
               err_in = pfe_pkg::ERR_OVERFLOW;
            end
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = final_ff;
         rsp_status_in = err_ff;
         count_in      = '0;
         err_in        = pfe_pkg::ERR_NONE;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         err_ff       <= pfe_pkg::ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sym_ff        <= sym_in;
      last_ff       <= last_in;
      hit_ff        <= hit_in;
      right_ff      <= right_in;
      left_ff       <= left_in;
      final_ff      <= final_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   pfe_ram #(
      .WIDTH (pfe_pkg::DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (count_m1[AW-1:0]),
      .rd_data (rd_data)
   );

   pfe_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start_alu),
      .op     (pfe_pkg::decode_op(sym_ff)),
      .left   (left_ff),
      .right  (right_ff),
      .done   (alu_done),
      .result (alu_result),
      .err    (alu_err)
   );

   always_comb begin
      stat.is_operand = pfe_pkg::is_operand(sym_ff);
      stat.last       = last_ff;
      stat.alu_done   = alu_done;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== hw/rtl/postfix_expression_evaluator_core.sv =====
// Top level of the postfix expression evaluator.
//
// req_chan carries one expression character per item (symbol, last). Operand
// characters push their value; operator characters pop right and left
// operands, apply + - * / ^ and push the result. The item with last set
// also pops the top of stack and returns it with the first error status on
// rsp_chan, then clears the stack and status.
// Items are taken one at a time: the next item is not accepted until the
// previous one is through. Operand characters only push. The divide is
// iterative and produces one quotient bit per cycle; the power loop
// squares the base for each exponent bit. A divide by zero, or an exponent
// that is not positive, skips the loop. The last item adds a final pop and
// then waits for the result register to be free. The stack memory takes
// one pop or push a cycle.
// Reset clears the stack count, status and result valid flag; the stack memory
// itself needs no clearing. While the receiver stalls, the result is held in
// the output register and the next items are still taken until another
// result is due, which then waits for the register to free.
module postfix_expression_evaluator_core #(
   parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   pfe_req_if.sink   req_chan,
   pfe_rsp_if.source rsp_chan
);

   pfe_pkg::cmd_type               cmd;
   pfe_pkg::stat_type              stat;
   logic                           req_ready;
   logic                           rsp_valid;
   logic [pfe_pkg::DATA_W-1:0]     rsp_value;
   logic [pfe_pkg::STATUS_W-1:0]   rsp_status;

   pfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfe_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_symbol (req_chan.symbol),
      .req_last   (req_chan.last),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   assign req_chan.ready  = req_ready;
   assign rsp_chan.valid  = rsp_valid;
   assign rsp_chan.value  = $signed(rsp_value);
   assign rsp_chan.status = rsp_status;

endmodule

// ===== hw/rtl/pfe_checker.sv =====
// Port-level assertions for the postfix expression evaluator, bound to the top level.
module pfe_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pfe_pkg::DATA_W-1:0]    rsp_value,
   input logic [pfe_pkg::STATUS_W-1:0]  rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_status))
      else $error("result payload changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while previous item still in work");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without item in work");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind postfix_expression_evaluator_core pfe_checker u_pfe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_value  (rsp_chan.value),
   .rsp_status (rsp_chan.status)
);
